// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr, msg)
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

// ===== rtl/annexb_pkg.sv =====
// Shared types and constants of the Annex B unit splitter.
`default_nettype none
package annexb_pkg;

  localparam int SIZE_BITS_DEF = 24;
  localparam int USIZE_W       = 24;
  localparam logic [USIZE_W-1:0] UNIT_SIZE_MAX = 24'hFFFFFF;

  // command queue depth, power of two
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

  localparam logic [7:0] BYTE_START    = 8'h01;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [1:0] ZRUN_MAX      = 2'd3;
  localparam logic [1:0] ZRUN_START    = 2'd2;
  localparam logic [4:0] DROP_TYPE_RST = 5'd6;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_TYPE   = 1'b1;

  // Work for the back end: release zeros, then the byte, then close on start/eos.
  typedef struct packed {
    logic [2:0] zeros;
    logic       has_byte;
    logic [7:0] data;
    logic       start;
    logic       eos;
  } cmd_t;

  typedef struct packed {
    logic       en;
    logic [4:0] ty;
  } drop_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/annexb_front.sv =====
// Front end: start code detection and zero hold, emits back-end commands.
`default_nettype none
module annexb_front
  import annexb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_stream_byte,
  input  wire logic       in_end_of_stream,
  input  wire logic       q_full,
  output logic            push,
  output cmd_t            cmd
);

  logic [1:0] zero_run_r, zero_run_nxt;
  logic       accept;
  logic       is_zero, is_start, nonempty;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    is_zero      = (in_stream_byte == BYTE_ZERO);
    is_start     = (in_stream_byte == BYTE_START) && (zero_run_r >= ZRUN_START);
    cmd.zeros    = 3'd0;
    cmd.has_byte = 1'b0;
    cmd.data     = in_stream_byte;
    cmd.start    = 1'b0;
    cmd.eos      = in_end_of_stream;
    zero_run_nxt = zero_run_r;
    priority if (is_zero) begin
      // a fourth zero pushes the oldest held one out
      if (zero_run_r == ZRUN_MAX) begin
        cmd.zeros = 3'd1;
      end else begin
        zero_run_nxt = zero_run_r + 2'd1;
      end
    end else if (is_start) begin
      cmd.start    = 1'b1;
      zero_run_nxt = 2'd0;
    end else begin
      cmd.zeros    = {1'b0, zero_run_r};
      cmd.has_byte = 1'b1;
      zero_run_nxt = 2'd0;
    end
    if (in_end_of_stream) begin
      cmd.zeros    = cmd.zeros + {1'b0, zero_run_nxt};
      zero_run_nxt = 2'd0;
    end
    nonempty = (cmd.zeros != 3'd0) || cmd.has_byte || cmd.start || cmd.eos;
  end

  assign push = accept && nonempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r <= 2'd0;
    end else if (accept) begin
      zero_run_r <= zero_run_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/annexb_cmd_fifo.sv =====
// Short command queue between front and back end.
`default_nettype none
module annexb_cmd_fifo
  import annexb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      wr_data,
  input  wire logic pop,
  output cmd_t      rd_data,
  output logic      full,
  output logic      empty
);

  cmd_t                 slot_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_PTR_W:0]   count_r;

  assign full    = (count_r == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/annexb_back.sv =====
// Back end: steps through each command, tracks the unit and drives results.
`default_nettype none
module annexb_back
  import annexb_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  drop_cfg_t               drop_cfg,
  input  wire logic               q_empty,
  input  cmd_t                    q_data,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_item_kind,
  output logic [7:0]              out_payload_byte,
  output logic [4:0]              out_unit_type,
  output logic                    out_unit_first,
  output logic [USIZE_W-1:0]      out_unit_size,
  output logic                    out_last
);

  localparam int ExtW = (SIZE_BITS > USIZE_W) ? SIZE_BITS : USIZE_W;

  cmd_t                 cur_r, cur_nxt;
  logic                 cur_valid_r, cur_valid_nxt;
  logic                 inside_r, inside_nxt;
  logic                 await_r, await_nxt;
  logic [4:0]           type_r, type_nxt;
  logic                 drop_r, drop_nxt;
  logic [SIZE_BITS-1:0] count_r, count_nxt;

  logic                 out_valid_r;
  logic                 kind_r, first_r, last_r;
  logic [7:0]           pbyte_r;
  logic [4:0]           utype_r;
  logic [USIZE_W-1:0]   usize_r;

  logic                 step_zero, step_close, close_req, final_step;
  logic [7:0]           ub_val;
  logic [4:0]           ub_type;
  logic                 ub_drop;
  logic [SIZE_BITS-1:0] ub_base, ub_count;
  logic                 emit, out_free, adv;
  logic [ExtW-1:0]      cnt_ext;
  logic [USIZE_W-1:0]   size_sat;

  always_comb begin
    close_req  = cur_r.start || cur_r.eos;
    step_zero  = (cur_r.zeros != 3'd0);
    step_close = !step_zero && !cur_r.has_byte;
    final_step = (cur_r.zeros == 3'd1 && !cur_r.has_byte && !close_req)
              || (cur_r.zeros == 3'd0 && cur_r.has_byte && !close_req)
              || step_close;

    // one unit byte: a pending header byte settles type and drop decision
    ub_val   = step_zero ? BYTE_ZERO : cur_r.data;
    ub_type  = await_r ? ub_val[4:0] : type_r;
    ub_drop  = await_r ? (drop_cfg.en && (ub_val[4:0] == drop_cfg.ty)) : drop_r;
    ub_base  = await_r ? '0 : count_r;
    ub_count = (ub_base != '1) ? ub_base + 1'b1 : ub_base;

    cnt_ext  = ExtW'(count_r);
    size_sat = (cnt_ext > ExtW'(UNIT_SIZE_MAX)) ? UNIT_SIZE_MAX : cnt_ext[USIZE_W-1:0];

    emit     = step_close ? (inside_r && !await_r && !drop_r) : (inside_r && !ub_drop);
    out_free = !out_valid_r || !out_stall;
    adv      = cur_valid_r && (!emit || out_free);
    pop      = !q_empty && (!cur_valid_r || (adv && final_step));

    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    inside_nxt    = inside_r;
    await_nxt     = await_r;
    type_nxt      = type_r;
    drop_nxt      = drop_r;
    count_nxt     = count_r;

    if (adv) begin
      if (step_close) begin
        if (cur_r.eos) begin
          inside_nxt = 1'b0;
          await_nxt  = 1'b0;
          type_nxt   = 5'd0;
          drop_nxt   = 1'b0;
          count_nxt  = '0;
        end else begin
          inside_nxt = 1'b1;
          await_nxt  = 1'b1;
        end
      end else begin
        if (inside_r) begin
          await_nxt = 1'b0;
          type_nxt  = ub_type;
          drop_nxt  = ub_drop;
          count_nxt = ub_count;
        end
        if (step_zero) begin
          cur_nxt.zeros = cur_r.zeros - 3'd1;
        end else begin
          cur_nxt.has_byte = 1'b0;
        end
      end
      if (final_step) cur_valid_nxt = 1'b0;
    end
    if (pop) begin
      cur_nxt       = q_data;
      cur_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      inside_r    <= 1'b0;
      await_r     <= 1'b0;
      type_r      <= 5'd0;
      drop_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      inside_r    <= inside_nxt;
      await_r     <= await_nxt;
      type_r      <= type_nxt;
      drop_r      <= drop_nxt;
      count_r     <= count_nxt;
      if (adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (adv && emit) begin
      kind_r  <= step_close ? KIND_END : KIND_PAYLOAD;
      pbyte_r <= step_close ? BYTE_ZERO : ub_val;
      utype_r <= step_close ? type_r : ub_type;
      first_r <= !step_close && await_r;
      usize_r <= step_close ? size_sat : '0;
      last_r  <= final_step;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_item_kind    = kind_r;
  assign out_payload_byte = pbyte_r;
  assign out_unit_type    = utype_r;
  assign out_unit_first   = first_r;
  assign out_unit_size    = usize_r;
  assign out_last         = last_r;

endmodule
`default_nettype wire

// ===== rtl/annexb_nal_unit_splitter_top.sv =====
// Top level of the Annex B NAL unit splitter.
`default_nettype none
`include "assert_macros.svh"
// Splits an H.264 Annex B byte stream at 00 00 01 start codes (a leading zero
// makes it a 4-byte code) and emits each unit byte with its 5-bit type and a
// header mark, followed by an end item with the saturating byte count. Bytes
// before the first start code and, when dropping is enabled, units of the
// configured drop type are discarded; end_of_stream flushes held zeros and
// closes the open unit. One byte is accepted per cycle while the back end
// keeps up. The back-end step sequencer works through a request one step at
// a time: each released zero, the byte itself, and the unit close are one
// step each, whether or not the step yields a result, and a stalled result
// holds the sequencer. A four-entry command queue lets the front keep
// accepting while the back end works through a burst; zeros held for start
// code detection are not passed to the back end until released.
module annexb_nal_unit_splitter_top
  import annexb_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_stream_byte,
  input  wire logic                  in_end_of_stream,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_item_kind,
  output logic [7:0]                 out_payload_byte,
  output logic [4:0]                 out_unit_type,
  output logic                       out_unit_first,
  output logic [USIZE_W-1:0]         out_unit_size,
  output logic                       out_last
);

  drop_cfg_t drop_cfg_r;
  cmd_t      push_cmd, pop_cmd;
  logic      push, pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_cfg_r.en <= 1'b1;
      drop_cfg_r.ty <= DROP_TYPE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DROP_ENABLE: drop_cfg_r.en <= cfg_wdata[0];
        CFG_DROP_TYPE:   drop_cfg_r.ty <= cfg_wdata[4:0];
        default:         drop_cfg_r    <= drop_cfg_r;
      endcase
    end
  end

  annexb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .in_end_of_stream (in_end_of_stream),
    .q_full           (q_full),
    .push             (push),
    .cmd              (push_cmd)
  );

  annexb_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_cmd),
    .pop     (pop),
    .rd_data (pop_cmd),
    .full    (q_full),
    .empty   (q_empty)
  );

  annexb_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .drop_cfg         (drop_cfg_r),
    .q_empty          (q_empty),
    .q_data           (pop_cmd),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item_kind    (out_item_kind),
    .out_payload_byte (out_payload_byte),
    .out_unit_type    (out_unit_type),
    .out_unit_first   (out_unit_first),
    .out_unit_size    (out_unit_size),
    .out_last         (out_last)
  );

  `ASSERT_ALWAYS(a_no_push_full, clk, rst_n, !(push && q_full), "request pushed into full queue")
  `ASSERT_ALWAYS(a_no_pop_empty, clk, rst_n, !(pop && q_empty), "request popped from empty queue")
  `ASSERT_IMPLIES(a_end_fields, clk, rst_n,
                  out_valid && (out_item_kind == KIND_END),
                  (out_payload_byte == BYTE_ZERO) && !out_unit_first,
                  "end item carries payload fields")
  `ASSERT_IMPLIES(a_payload_size, clk, rst_n,
                  out_valid && (out_item_kind == KIND_PAYLOAD),
                  out_unit_size == '0,
                  "payload item carries a size")

endmodule
`default_nettype wire
